/* rtl/deque_pkg.sv */
// ----------------------------------------------------------------------------
// deque_pkg
// Shared sizes, request and status codes, types and ring pointer helpers
// for the double-ended queue.
// ----------------------------------------------------------------------------
package deque_pkg;

    localparam int DEPTH = 64;
    localparam int WIDTH = 32;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef logic [1:0]              kind_t;
    typedef logic [1:0]              status_t;
    typedef logic signed [WIDTH-1:0] word_t;
    typedef logic [PTR_W-1:0]        ptr_t;
    typedef logic [CNT_W-1:0]        cnt_t;

    localparam kind_t KIND_PUSH_FRONT = 2'd0;
    localparam kind_t KIND_POP_FRONT  = 2'd1;
    localparam kind_t KIND_INJECT     = 2'd2;
    localparam kind_t KIND_EJECT      = 2'd3;

    localparam status_t STAT_OK    = 2'd0;
    localparam status_t STAT_FULL  = 2'd1;
    localparam status_t STAT_EMPTY = 2'd2;

    localparam ptr_t PTR_LAST = PTR_W'(DEPTH - 1);
    localparam cnt_t CNT_FULL = CNT_W'(DEPTH);

    typedef struct packed {
        logic load;
        logic exec;
    } deque_cmd_t;

    function automatic ptr_t ptr_next(input ptr_t p);
        return (p == PTR_LAST) ? '0 : ptr_t'(p + 1'b1);
    endfunction

    function automatic ptr_t ptr_prev(input ptr_t p);
        return (p == '0) ? PTR_LAST : ptr_t'(p - 1'b1);
    endfunction

endpackage

/* rtl/deque_ctrl.sv */
// ----------------------------------------------------------------------------
// deque_ctrl
// Request sequencer: accept a request, run one ring access, then present
// the result beat for one cycle.
// ----------------------------------------------------------------------------
module deque_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    output deque_pkg::deque_cmd_t cmd
);
    import deque_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_ACCESS = 2'd1;
    localparam logic [1:0] S_RESULT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_ACCESS;
                end
            end
            S_ACCESS: state_next = S_RESULT;
            S_RESULT: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = (state_reg == S_RESULT);
    assign cmd.load = (state_reg == S_IDLE) && start;
    assign cmd.exec = (state_reg == S_ACCESS);

    a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.exec) else $error("access did not follow accept");
    a_exec_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> done) else $error("result beat did not follow access");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy) else $error("result beat longer than one cycle");

endmodule

/* rtl/deque_dp.sv */
// ----------------------------------------------------------------------------
// deque_dp
// Ring store with head and tail pointers and a fill count; holds the
// request, performs or refuses one insert or removal and registers the result.
// ----------------------------------------------------------------------------
module deque_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  deque_pkg::deque_cmd_t cmd,
    input  deque_pkg::kind_t      kind,
    input  deque_pkg::word_t      value_in,
    output deque_pkg::word_t      value_out,
    output deque_pkg::status_t    status
);
    import deque_pkg::*;

    word_t   mem [DEPTH];

    kind_t   kind_reg;
    word_t   word_reg;
    word_t   data_reg;
    status_t status_reg;
    status_t status_next;
    ptr_t    head_reg;
    ptr_t    head_next;
    ptr_t    tail_reg;
    ptr_t    tail_next;
    cnt_t    cnt_reg;
    cnt_t    cnt_next;

    ptr_t    addr;
    logic    is_insert;
    logic    has_room;
    logic    has_data;
    logic    wr_en;
    logic    rd_en;

    assign is_insert = (kind_reg == KIND_PUSH_FRONT) || (kind_reg == KIND_INJECT);
    assign has_room  = (cnt_reg != CNT_FULL);
    assign has_data  = (cnt_reg != '0);
    assign wr_en     = cmd.exec && is_insert && has_room;
    assign rd_en     = cmd.exec && !is_insert && has_data;

    always_comb
    begin
        unique case (kind_reg)
            KIND_PUSH_FRONT: addr = ptr_prev(head_reg);
            KIND_POP_FRONT:  addr = head_reg;
            KIND_INJECT:     addr = tail_reg;
            KIND_EJECT:      addr = ptr_prev(tail_reg);
            default:         addr = head_reg;
        endcase
    end

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        if (cmd.exec)
        begin
            status_next = STAT_OK;
            priority if (is_insert && !has_room)
            begin
                status_next = STAT_FULL;
            end
            else if (!is_insert && !has_data)
            begin
                status_next = STAT_EMPTY;
            end
            else
            begin
                unique case (kind_reg)
                    KIND_PUSH_FRONT: head_next = addr;
                    KIND_POP_FRONT:  head_next = ptr_next(head_reg);
                    KIND_INJECT:     tail_next = ptr_next(tail_reg);
                    KIND_EJECT:      tail_next = addr;
                    default:         head_next = head_reg;
                endcase
                cnt_next = is_insert ? cnt_t'(cnt_reg + 1'b1) : cnt_t'(cnt_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            cnt_reg    <= '0;
            status_reg <= STAT_OK;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            cnt_reg    <= cnt_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            word_reg <= value_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= word_reg;
        end
        if (cmd.exec)
        begin
            data_reg <= rd_en ? mem[addr] : '0;
        end
    end

    assign value_out = data_reg;
    assign status    = status_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL) else $error("fill count above depth");
    a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && is_insert && !has_room |=> status_reg == STAT_FULL && $stable(cnt_reg))
        else $error("insert into full ring not refused");
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec |=> $stable(cnt_reg) && $stable(head_reg) && $stable(tail_reg))
        else $error("ring state moved without access");

endmodule

/* rtl/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed words in a 64-entry ring store.
//
// Request channel: drive kind and value_in with start high; the beat is taken
// at a rising edge where start is high and busy is low. kind selects push at
// the front, pop from the front, inject at the rear or eject from the rear.
// Result channel: every request yields exactly one result beat, marked by
// done for one cycle, with value_out (removed word, zero otherwise) and
// status (ok, full for a refused insert, empty for a refused removal).
// Sequencing: an accepted request moves through an access state, in which the
// ring store is read or written, and then the result state; busy stays high
// until the result beat is delivered, so no new request is taken before then.
// Reset clears head, tail and fill count; the queue is then empty.
// The receiver cannot stall: a result beat is valid for its single cycle only.
// ----------------------------------------------------------------------------
module double_ended_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  deque_pkg::kind_t   kind,
    input  deque_pkg::word_t   value_in,
    output logic               done,
    output deque_pkg::word_t   value_out,
    output deque_pkg::status_t status
);
    import deque_pkg::*;

    deque_cmd_t cmd;

    deque_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    deque_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .kind      (kind),
        .value_in  (value_in),
        .value_out (value_out),
        .status    (status)
    );

endmodule

/* tb/double_ended_queue_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the double-ended queue. Directed push, pop, inject
// and eject requests cover the word extremes and the empty cases. Random
// bursts that lean toward filling, draining or a mix drive the ring to full,
// to empty and around its wrap points. Every result beat is compared in issue
// order with a behavioral ring-store model kept inside the bench.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
    import deque_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_ITEMS  = 490;

    typedef struct packed {
        kind_t op;
        word_t word;
    } request_t;

    typedef struct packed {
        word_t   word;
        status_t stat;
    } outcome_t;

    logic    clk      = 1'b0;
    logic    rst_n    = 1'b0;
    logic    start    = 1'b0;
    kind_t   kind     = KIND_PUSH_FRONT;
    word_t   value_in = '0;
    logic    busy;
    logic    done;
    word_t   value_out;
    status_t status;

    request_t request_q[$];
    outcome_t outcome_q[$];
    int       idle_pct     = 0;
    int       mismatch_cnt = 0;
    int       quiet_cycles = 0;
    logic     beat_taken   = 1'b0;

    word_t ring_mem[DEPTH];
    ptr_t  front_idx = '0;
    ptr_t  back_idx  = '0;
    int    held_cnt  = 0;

    double_ended_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .value_in  (value_in),
        .done      (done),
        .value_out (value_out),
        .status    (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic outcome_t deque_apply(request_t req);
        outcome_t res;
        res.word = '0;
        res.stat = STAT_OK;
        if (req.op == KIND_PUSH_FRONT || req.op == KIND_INJECT)
        begin
            if (held_cnt == DEPTH)
            begin
                res.stat = STAT_FULL;
            end
            else if (req.op == KIND_PUSH_FRONT)
            begin
                front_idx = ptr_t'((int'(front_idx) + DEPTH - 1) % DEPTH);
                ring_mem[front_idx] = req.word;
                held_cnt++;
            end
            else
            begin
                ring_mem[back_idx] = req.word;
                back_idx = ptr_t'((int'(back_idx) + 1) % DEPTH);
                held_cnt++;
            end
        end
        else
        begin
            if (held_cnt == 0)
            begin
                res.stat = STAT_EMPTY;
            end
            else if (req.op == KIND_POP_FRONT)
            begin
                res.word = ring_mem[front_idx];
                front_idx = ptr_t'((int'(front_idx) + 1) % DEPTH);
                held_cnt--;
            end
            else
            begin
                back_idx = ptr_t'((int'(back_idx) + DEPTH - 1) % DEPTH);
                res.word = ring_mem[back_idx];
                held_cnt--;
            end
        end
        return res;
    endfunction

    task automatic log_fault(string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
        begin
            $display("[%0t] %s", $time, msg);
        end
    endtask

    // Check result beats first, then record the request beat of this edge.
    always @(posedge clk)
    begin : monitor
        outcome_t want;
        request_t req;
        if (done)
        begin
            if (outcome_q.size() == 0)
            begin
                log_fault($sformatf("unexpected result value %0d status %0d",
                                    value_out, status));
            end
            else
            begin
                want = outcome_q.pop_front();
                if (value_out !== want.word || status !== want.stat)
                begin
                    log_fault($sformatf("exp value %0d status %0d, got value %0d status %0d",
                                        want.word, want.stat, value_out, status));
                end
            end
        end
        if (rst_n && start && !busy)
        begin
            req.op   = kind;
            req.word = value_in;
            outcome_q.push_back(deque_apply(req));
        end
        beat_taken <= rst_n && start && !busy;
        if (!rst_n || done || (start && !busy))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("double_ended_queue_tb NOT OK");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Hold the beat until taken, then advance or idle.
    always @(negedge clk)
    begin : driver
        request_t nxt;
        if (rst_n && (!start || beat_taken))
        begin
            if (request_q.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                nxt = request_q.pop_front();
                start    <= 1'b1;
                kind     <= nxt.op;
                value_in <= nxt.word;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        request_t opening[18];
        int       idle_plan[4];
        request_t req;
        int       n;
        int       mode;
        int       run;
        int       ins_pct;

        opening = '{
            '{KIND_POP_FRONT,  word_t'(32'h1234_5678)},
            '{KIND_EJECT,      word_t'(32'hFFFF_FFFF)},
            '{KIND_PUSH_FRONT, word_t'(32'h7FFF_FFFF)},
            '{KIND_PUSH_FRONT, word_t'(32'h8000_0000)},
            '{KIND_INJECT,     word_t'(32'h0000_0000)},
            '{KIND_INJECT,     word_t'(32'hFFFF_FFFF)},
            '{KIND_INJECT,     word_t'(32'h5555_5555)},
            '{KIND_PUSH_FRONT, word_t'(32'hAAAA_AAAA)},
            '{KIND_POP_FRONT,  word_t'(32'hDEAD_0001)},
            '{KIND_EJECT,      word_t'(32'h0000_0000)},
            '{KIND_EJECT,      word_t'(32'h7FFF_FFFF)},
            '{KIND_POP_FRONT,  word_t'(32'h8000_0000)},
            '{KIND_POP_FRONT,  word_t'(32'h0F0F_0F0F)},
            '{KIND_EJECT,      word_t'(32'hF0F0_F0F0)},
            '{KIND_POP_FRONT,  word_t'(32'h0000_0001)},
            '{KIND_EJECT,      word_t'(32'h0000_0002)},
            '{KIND_INJECT,     word_t'(32'h0000_0001)},
            '{KIND_EJECT,      word_t'(32'h0000_0003)}
        };
        idle_plan = '{0, 54, 0, 18};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (opening[i])
        begin
            request_q.push_back(opening[i]);
        end
        while (request_q.size() != 0) @(negedge clk);

        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = idle_plan[phase];
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                // Lean each burst toward filling, draining or a mix.
                mode    = $urandom_range(2);
                ins_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
                run     = $urandom_range(128, 16);
                if (run > PHASE_ITEMS - n)
                begin
                    run = PHASE_ITEMS - n;
                end
                repeat (run)
                begin
                    if ($urandom_range(99) < ins_pct)
                    begin
                        req.op = $urandom_range(1) ? KIND_INJECT : KIND_PUSH_FRONT;
                    end
                    else
                    begin
                        req.op = $urandom_range(1) ? KIND_EJECT : KIND_POP_FRONT;
                    end
                    case ($urandom_range(15))
                        0:       req.word = word_t'(32'h7FFF_FFFF);
                        1:       req.word = word_t'(32'h8000_0000);
                        2:       req.word = '0;
                        3:       req.word = '1;
                        default: req.word = word_t'($urandom);
                    endcase
                    request_q.push_back(req);
                end
                n += run;
            end
            while (request_q.size() != 0) @(negedge clk);
        end

        while (start || outcome_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0 && outcome_q.size() == 0)
        begin
            $display("double_ended_queue_tb OK");
        end
        else
        begin
            $display("double_ended_queue_tb NOT OK");
        end
        $finish;
    end

endmodule
